@@ rtl/gia_pkg.sv @@
package gia_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = IDX_W + 1;
	localparam int ROW_W      = 32;
	localparam int BIT_W      = $clog2(ROW_W);
	localparam int ROWS       = HEAP_DEPTH / ROW_W;
	localparam int ROW_AW     = $clog2(ROWS);

	localparam int FUNC_W     = 2;
	localparam int SLOT_W     = 11;
	localparam int GRANT_W    = 10;
	localparam int ADDR_W     = 48;
	localparam int STAT_W     = 2;
	localparam int HSIZE_W    = 11;
	localparam int INC_W      = 13;
	localparam int PROD_W     = SLOT_W + INC_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [HSIZE_W-1:0] HSIZE_RST = HSIZE_W'(1024);
	localparam logic [INC_W-1:0]   INC_RST   = INC_W'(32);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAP_SIZE = 2'd0,
		REG_INCREMENT = 2'd1,
		REG_CPU_BASE  = 2'd2,
		REG_GPU_BASE  = 2'd3
	} reg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 2'd0,
		FN_RELEASE = 2'd1,
		FN_CPU     = 2'd2,
		FN_GPU     = 2'd3
	} fn_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_INVALID = 2'd3
	} st_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_GROW,
		S_RMW_RD,
		S_RMW_WR,
		S_MUL,
		S_ADD,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic take;
		logic grow;
		logic rd;
		logic wr;
		logic mul;
		logic add;
		logic set_status;
		st_t  code;
	} cmd_t;

	typedef struct packed {
		fn_t  func;
		logic invalid;
		logic out_range;
		logic hit;
		logic miss;
		logic grow_ok;
	} sts_t;

endpackage

@@ rtl/growing_index_allocator_core.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_stall    func, slot_index
// out      out_valid / out_stall  granted_index, handle_address, status
// cfg      cfg_write              cfg_index, cfg_data
//
// One request at a time. Allocate scans the used-bit RAM one 32-bit row per
// cycle from the top of the reserve down, set by the single RAM read port.
// Release goes through RMW read and write, handle requests through multiply
// and add; rejects (invalid marker or out of range) go straight to response.
// Reset clears the per-row valid bits, so no clearing pass is needed.
// A result beat holds until out_stall drops; in_stall stays high meanwhile.
module growing_index_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [gia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gia_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [gia_pkg::FUNC_W-1:0]    func,
	input  logic [gia_pkg::SLOT_W-1:0]    slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gia_pkg::GRANT_W-1:0]   granted_index,
	output logic [gia_pkg::ADDR_W-1:0]    handle_address,
	output logic [gia_pkg::STAT_W-1:0]    status
);
	import gia_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	gia_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.slot_index     (slot_index),
		.granted_index  (granted_index),
		.handle_address (handle_address),
		.status         (status),
		.cmd            (cmd),
		.sts            (sts)
	);

endmodule

@@ rtl/gia_ctrl.sv @@
module gia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  gia_pkg::sts_t sts,
	output gia_pkg::cmd_t cmd
);
	import gia_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.code  = ST_OK;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.func)
					FN_ALLOC: begin
						state_d = S_SCAN;
					end
					FN_RELEASE: begin
						if (sts.invalid) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_INVALID;
							state_d        = S_RESP;
						end else if (sts.out_range) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_RANGE;
							state_d        = S_RESP;
						end else begin
							state_d = S_RMW_RD;
						end
					end
					default: begin
						if (sts.out_range) begin
							cmd.set_status = 1'b1;
							cmd.code       = ST_RANGE;
							state_d        = S_RESP;
						end else begin
							state_d = S_MUL;
						end
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					cmd.take = 1'b1;
					state_d  = S_RMW_RD;
				end else if (sts.miss) begin
					state_d = S_GROW;
				end
			end
			S_GROW: begin
				cmd.grow = 1'b1;
				if (sts.grow_ok) begin
					state_d = S_RMW_RD;
				end else begin
					cmd.set_status = 1'b1;
					cmd.code       = ST_FULL;
					state_d        = S_RESP;
				end
			end
			S_RMW_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_RMW_WR;
			end
			S_RMW_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_RESP;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/gia_dpath.sv @@
module gia_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [gia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gia_pkg::ADDR_W-1:0]    cfg_data,
	input  logic [gia_pkg::FUNC_W-1:0]    func,
	input  logic [gia_pkg::SLOT_W-1:0]    slot_index,
	output logic [gia_pkg::GRANT_W-1:0]   granted_index,
	output logic [gia_pkg::ADDR_W-1:0]    handle_address,
	output logic [gia_pkg::STAT_W-1:0]    status,
	input  gia_pkg::cmd_t                 cmd,
	output gia_pkg::sts_t                 sts
);
	import gia_pkg::*;

	// configuration
	logic [HSIZE_W-1:0] heap_size_q;
	logic [INC_W-1:0]   inc_q;
	logic [ADDR_W-1:0]  cpu_base_q;
	logic [ADDR_W-1:0]  gpu_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q <= HSIZE_RST;
			inc_q       <= INC_RST;
			cpu_base_q  <= '0;
			gpu_base_q  <= '0;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_HEAP_SIZE: heap_size_q <= cfg_data[HSIZE_W-1:0];
				REG_INCREMENT: inc_q       <= cfg_data[INC_W-1:0];
				REG_CPU_BASE:  cpu_base_q  <= cfg_data;
				REG_GPU_BASE:  gpu_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// request and reserve
	fn_t               func_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  rc_q;
	logic [IDX_W-1:0]  target_q;

	logic [IDX_W-1:0]  top_idx;
	logic [ROW_AW-1:0] top_row;
	logic [BIT_W-1:0]  top_bit;
	assign top_idx = IDX_W'(rc_q - CNT_W'(1));
	assign top_row = top_idx[IDX_W-1:BIT_W];
	assign top_bit = top_idx[BIT_W-1:0];

	// growth: double, clamped to heap_size limited to 1..HEAP_DEPTH
	logic [CNT_W-1:0] lim;
	logic [CNT_W:0]   dbl;
	logic [CNT_W-1:0] grown;
	always_comb begin
		if (heap_size_q == '0) begin
			lim = CNT_W'(1);
		end else if (CNT_W'(heap_size_q) > CNT_W'(HEAP_DEPTH)) begin
			lim = CNT_W'(HEAP_DEPTH);
		end else begin
			lim = CNT_W'(heap_size_q);
		end
		dbl = {rc_q, 1'b0};
		if (dbl > {1'b0, lim}) begin
			grown = lim;
		end else begin
			grown = dbl[CNT_W-1:0];
		end
	end

	// used-bit memory; rows never written read as zero, and bits at or above
	// the reserve are never set, so growth needs no fill
	logic [ROW_W-1:0]  mem [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [ROW_W-1:0]  rd_data_q;
	logic              rd_vld_q;
	logic              rd_en;
	logic [ROW_AW-1:0] rd_addr;
	logic [ROW_W-1:0]  eff_row;
	logic [ROW_W-1:0]  wr_row;
	logic [ROW_W-1:0]  bit_sel;
	logic [ROW_AW-1:0] tgt_row;

	logic [ROW_AW-1:0] scan_row_q;
	logic              scan_live_q;
	logic              pend_s1;
	logic [ROW_AW-1:0] row_s1;

	assign tgt_row = target_q[IDX_W-1:BIT_W];
	assign rd_en   = (cmd.scan && scan_live_q) || cmd.rd;
	assign rd_addr = cmd.scan ? scan_row_q : tgt_row;
	assign eff_row = rd_vld_q ? rd_data_q : '0;
	assign bit_sel = ROW_W'(1) << target_q[BIT_W-1:0];
	assign wr_row  = (func_q == FN_ALLOC) ? (eff_row | bit_sel) : (eff_row & ~bit_sel);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[tgt_row] <= wr_row;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.wr) begin
				row_vld_q[tgt_row] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// scan: one row issued per cycle, top row down, evaluated from the registered read data
	logic [ROW_W-1:0] row_mask;
	logic [ROW_W-1:0] free_vec;
	logic [BIT_W-1:0] hit_bit;
	logic             any_free;
	always_comb begin
		for (int b = 0; b < ROW_W; b++) begin
			row_mask[b] = (row_s1 != top_row) || (BIT_W'(b) <= top_bit);
		end
		free_vec = ~eff_row & row_mask;
		hit_bit  = '0;
		for (int b = 0; b < ROW_W; b++) begin
			if (free_vec[b]) begin
				hit_bit = BIT_W'(b);
			end
		end
		any_free = |free_vec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_live_q <= 1'b0;
			pend_s1     <= 1'b0;
		end else if (cmd.load) begin
			scan_live_q <= 1'b1;
			pend_s1     <= 1'b0;
		end else if (cmd.scan) begin
			pend_s1 <= scan_live_q;
			if (scan_live_q && scan_row_q == '0) begin
				scan_live_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			scan_row_q <= top_row;
		end else if (cmd.scan && scan_live_q) begin
			row_s1 <= scan_row_q;
			if (scan_row_q != '0) begin
				scan_row_q <= scan_row_q - ROW_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= CNT_W'(1);
		end else if (cmd.grow && (grown > rc_q)) begin
			rc_q <= grown;
		end
	end

	logic [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0] base;
	assign base = (func_q == FN_CPU) ? cpu_base_q : gpu_base_q;

	logic [GRANT_W-1:0] granted_q;
	logic [ADDR_W-1:0]  addr_q;
	st_t                status_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= fn_t'(func);
			slot_q    <= slot_index;
			target_q  <= slot_index[IDX_W-1:0];
			granted_q <= '0;
			addr_q    <= '0;
			status_q  <= ST_OK;
		end else begin
			if (cmd.take) begin
				target_q <= {row_s1, hit_bit};
			end
			if (cmd.grow) begin
				target_q <= IDX_W'(grown - CNT_W'(1));
			end
			if (cmd.mul) begin
				prod_q <= slot_q * inc_q;
			end
			if (cmd.add) begin
				addr_q <= base + ADDR_W'(prod_q);
			end
			if (cmd.wr && func_q == FN_ALLOC) begin
				granted_q <= GRANT_W'(target_q);
			end
			if (cmd.set_status) begin
				status_q <= cmd.code;
			end
		end
	end

	assign sts.func      = func_q;
	assign sts.invalid   = (slot_q == SLOT_W'(HEAP_DEPTH));
	assign sts.out_range = (CNT_W'(slot_q) >= rc_q);
	assign sts.hit       = pend_s1 && any_free;
	assign sts.miss      = pend_s1 && !any_free && (row_s1 == '0);
	assign sts.grow_ok   = (grown > rc_q);

	assign granted_index  = granted_q;
	assign handle_address = addr_q;
	assign status         = status_q;

endmodule

@@ test/tb_growing_index_allocator_core.sv @@
`timescale 1ns / 100ps

module tb_growing_index_allocator_core;
	import gia_pkg::*;

	localparam int LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		fn_t               op;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [GRANT_W-1:0] grant;
		logic [ADDR_W-1:0]  addr;
		st_t                stat;
	} beat_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HEAP_SIZE;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [FUNC_W-1:0]    func = FN_ALLOC;
	logic [SLOT_W-1:0]    slot_index = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [GRANT_W-1:0]   granted_index;
	logic [ADDR_W-1:0]    handle_address;
	logic [STAT_W-1:0]    status;

	// allocator shadow state and register copy
	logic [HEAP_DEPTH-1:0] free_bits;
	int                    resv;
	logic [HSIZE_W-1:0]    hsize_cfg = HSIZE_RST;
	logic [INC_W-1:0]      inc_cfg = INC_RST;
	logic [ADDR_W-1:0]     cpu_cfg = '0;
	logic [ADDR_W-1:0]     gpu_cfg = '0;

	req_t  pend_q[$];
	beat_t grant_q[$];
	req_t  cur;

	bit calm = 1'b0;
	bit press_req = 1'b0;
	bit press_done = 1'b0;
	int hold_left = 0;
	int cyc = 0;
	int n_err = 0;
	int n_acc = 0;
	int n_beats = 0;
	int stat_cnt[4] = '{0, 0, 0, 0};

	growing_index_allocator_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.slot_index     (slot_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted_index  (granted_index),
		.handle_address (handle_address),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	initial begin
		wait (cyc >= LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cyc, grant_q.size());
		$display("growing_index_allocator_core: mismatch");
		$finish;
	end

	// Applies one request to the shadow allocator and returns its result beat.
	function automatic beat_t serve(req_t r);
		beat_t b;
		int    lim;
		int    grown;
		int    idx;
		int    i;
		bit    hit;
		b.grant = '0;
		b.addr = '0;
		b.stat = ST_OK;
		hit = 1'b0;
		idx = 0;
		case (r.op)
			FN_ALLOC: begin
				i = resv;
				while (!hit && i > 0) begin
					i--;
					if (free_bits[i]) begin
						hit = 1'b1;
						idx = i;
					end
				end
				if (!hit) begin
					lim = (hsize_cfg == 0) ? 1 : (hsize_cfg > HEAP_DEPTH ? HEAP_DEPTH : hsize_cfg);
					grown = resv * 2;
					if (grown > lim)
						grown = lim;
					if (grown <= resv) begin
						b.stat = ST_FULL;
					end else begin
						for (i = resv; i < grown; i++)
							free_bits[i] = 1'b1;
						resv = grown;
						idx = grown - 1;
					end
				end
				if (b.stat == ST_OK) begin
					free_bits[idx] = 1'b0;
					b.grant = GRANT_W'(idx);
				end
			end
			FN_RELEASE: begin
				if (r.slot == HEAP_DEPTH)
					b.stat = ST_INVALID;
				else if (r.slot >= resv)
					b.stat = ST_RANGE;
				else
					free_bits[r.slot] = 1'b1;
			end
			default: begin
				// handle sum wraps at 48 bits
				if (r.slot >= resv)
					b.stat = ST_RANGE;
				else
					b.addr = (r.op == FN_CPU ? cpu_cfg : gpu_cfg)
						+ ADDR_W'(r.slot) * ADDR_W'(inc_cfg);
			end
		endcase
		return b;
	endfunction

	function automatic req_t pick_req(int p_alloc, int p_rel);
		req_t r;
		int   roll;
		roll = $urandom_range(99);
		if (roll < p_alloc)
			r.op = FN_ALLOC;
		else if (roll < p_alloc + p_rel)
			r.op = FN_RELEASE;
		else
			r.op = $urandom_range(1) ? FN_GPU : FN_CPU;
		roll = $urandom_range(99);
		if (roll < 80)
			r.slot = SLOT_W'($urandom_range(resv - 1, 0));
		else if (roll < 88)
			r.slot = SLOT_W'(resv + $urandom_range(3));
		else if (roll < 94)
			r.slot = SLOT_W'(HEAP_DEPTH);
		else
			r.slot = SLOT_W'($urandom_range(2047));
		return r;
	endfunction

	task automatic flag(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
		n_err++;
		if (n_err <= 10)
			$display("%0t: %s exp %h got %h", $realtime, what, want, got);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FN_ALLOC;
			slot_index <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				grant_q.push_back(serve(cur));
				stat_cnt[grant_q[$].stat]++;
				n_acc++;
			end
			if (!in_valid || !in_stall) begin
				if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
					cur = pend_q.pop_front();
					in_valid <= 1'b1;
					func <= cur.op;
					slot_index <= cur.slot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			press_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (press_req && !press_done) begin
			press_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 20);
		end
	end

	// result checker
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_beats++;
			if (grant_q.size() == 0) begin
				flag("unexpected beat, status", '0, ADDR_W'(status));
			end else begin
				want = grant_q.pop_front();
				if (granted_index !== want.grant)
					flag("granted_index", ADDR_W'(want.grant), ADDR_W'(granted_index));
				if (handle_address !== want.addr)
					flag("handle_address", want.addr, handle_address);
				if (status !== want.stat)
					flag("status", ADDR_W'(want.stat), ADDR_W'(status));
			end
		end
	end

	task automatic drain();
		do
			@(negedge clk);
		while (pend_q.size() != 0 || in_valid || grant_q.size() != 0);
	endtask

	task automatic load_regs(logic [HSIZE_W-1:0] hs, logic [INC_W-1:0] inc,
	                         logic [ADDR_W-1:0] cb, logic [ADDR_W-1:0] gb);
		reg_idx_t          r;
		logic [ADDR_W-1:0] v;
		int                k;
		for (k = 0; k < 4; k++) begin
			r = reg_idx_t'(k);
			case (r)
				REG_HEAP_SIZE: v = ADDR_W'(hs);
				REG_INCREMENT: v = ADDR_W'(inc);
				REG_CPU_BASE:  v = cb;
				default:       v = gb;
			endcase
			@(posedge clk);
			cfg_write <= 1'b1;
			cfg_index <= r;
			cfg_data <= v;
		end
		@(posedge clk);
		cfg_write <= 1'b0;
		hsize_cfg = hs;
		inc_cfg = inc;
		cpu_cfg = cb;
		gpu_cfg = gb;
	endtask

	task automatic push(fn_t op, int slot);
		req_t r;
		r.op = op;
		r.slot = SLOT_W'(slot);
		pend_q.push_back(r);
	endtask

	task automatic run_random(int count, int p_alloc, int p_rel);
		int n;
		n = 0;
		while (n < count) begin
			@(negedge clk);
			if (pend_q.size() < 2) begin
				pend_q.push_back(pick_req(p_alloc, p_rel));
				n++;
			end
		end
		drain();
	endtask

	function automatic logic [ADDR_W-1:0] rnd48();
		return ADDR_W'({$urandom(), $urandom()});
	endfunction

	initial begin
		free_bits = '0;
		free_bits[0] = 1'b1;
		resv = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values: handles on slot 0, range and marker cases, allocation growth and releases
		push(FN_CPU, 0);
		push(FN_GPU, 0);
		push(FN_CPU, 1);
		push(FN_GPU, HEAP_DEPTH);
		push(FN_CPU, 2047);
		push(FN_RELEASE, HEAP_DEPTH);
		push(FN_RELEASE, 2047);
		push(FN_RELEASE, 1);
		push(FN_RELEASE, 0);
		push(FN_ALLOC, 0);
		push(FN_ALLOC, 0);
		push(FN_ALLOC, 0);
		push(FN_ALLOC, 0);
		push(FN_RELEASE, 0);
		push(FN_RELEASE, 0);
		push(FN_ALLOC, 0);
		drain();

		// zero heap size clamps to one: reserve cannot grow; handles wrap
		load_regs('0, 13'h1fff, 48'hffff_ffff_ffff, 48'h8000_0000_0000);
		push(FN_ALLOC, 0);
		push(FN_CPU, 3);
		push(FN_GPU, 3);
		push(FN_RELEASE, 2);
		push(FN_ALLOC, 0);
		drain();

		// growth capped below double, then full at the cap
		load_regs(11'd5, 13'd1, '0, 48'hffff_ffff_ffff);
		push(FN_ALLOC, 0);
		push(FN_ALLOC, 0);
		push(FN_GPU, 4);
		drain();

		load_regs(11'd64, INC_W'($urandom_range(4096, 1)), rnd48(), rnd48());
		run_random(100, 75, 20);

		// oversized heap clamps to full depth; no gaps on either side
		calm = 1'b1;
		load_regs(11'd2047, 13'd4096, 48'hffff_ffff_ffff, rnd48());
		run_random(300, 88, 6);
		calm = 1'b0;

		press_req = 1'b1;
		load_regs(11'd1024, '0, rnd48(), rnd48());
		run_random(80, 40, 40);

		load_regs(11'd1, 13'h1fff, '0, rnd48());
		run_random(60, 40, 40);

		load_regs(11'd1024, INC_W'($urandom_range(8191)), rnd48(), rnd48());
		run_random(80, 50, 30);

		repeat (40) @(posedge clk);
		if (grant_q.size() != 0) begin
			$display("%0d expected beats never arrived", grant_q.size());
			n_err += grant_q.size();
		end
		$display("%0d requests, %0d result beats; reserve grew to %0d slots",
			n_acc, n_beats, resv);
		$display("status mix: ok %0d, heap full %0d, out of range %0d, invalid marker %0d",
			stat_cnt[ST_OK], stat_cnt[ST_FULL], stat_cnt[ST_RANGE], stat_cnt[ST_INVALID]);
		if (n_err == 0)
			$display("growing_index_allocator_core: match");
		else
			$display("growing_index_allocator_core: mismatch");
		$finish;
	end

endmodule

@@ growing_index_allocator_core.f @@
rtl/gia_pkg.sv
rtl/gia_ctrl.sv
rtl/gia_dpath.sv
rtl/growing_index_allocator_core.sv
test/tb_growing_index_allocator_core.sv
